/* hdl/sliding_window_link_load_meter_unit_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the link load meter
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_LINK_LOAD_METER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_LINK_LOAD_METER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define SWLLM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequent holds in the cycle after the antecedent
`define SWLLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SWLLM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWLLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/swllm_pkg.sv */
// ----------------------------------------------------------------------------
// swllm_pkg
// shared constants, state types and load unit interface of the load meter
// ----------------------------------------------------------------------------
package swllm_pkg;

	localparam int HISTORY_DEPTH_DEF = 256;
	localparam int TIME_WIDTH_DEF    = 48;

	localparam int NOW_W      = 48;
	localparam int BITS_W     = 20;
	localparam int WIN_W      = 24;
	localparam int BW_W       = 32;
	localparam int SUM_OUT_W  = 28;
	localparam int LOAD_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int MICRO_W    = 20;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DEN_W      = WIN_W + BW_W;
	localparam int MUL_STEPS  = WIN_W;
	localparam int DIV_STEPS  = LOAD_W;

	localparam logic [WIN_W-1:0]     WINDOW_RESET    = 24'd10000000;
	localparam logic [BW_W-1:0]      BANDWIDTH_RESET = 32'd56000;
	localparam logic [MICRO_W-1:0]   MICROS_PER_S    = 20'd1000000;
	localparam logic [SUM_OUT_W-1:0] SUM_MAX         = '1;
	localparam logic [LOAD_W-1:0]    LOAD_MAX        = '1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_US   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_BW     = 2'd1;

	// item kind carried in tuser
	typedef enum logic {
		KIND_RECORD = 1'b0,
		KIND_QUERY  = 1'b1
	} item_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_PUSH,
		ST_CALC,
		ST_WAIT,
		ST_OUT
	} meter_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_MUL,
		DV_CHECK,
		DV_DIV
	} div_state_t;

	typedef struct packed {
		logic                 start;
		logic [SUM_OUT_W-1:0] sum;
		logic [WIN_W-1:0]     elapsed;
		logic [BW_W-1:0]      bandwidth;
	} load_req_t;

	typedef struct packed {
		logic              done;
		logic [LOAD_W-1:0] load;
	} load_rsp_t;

endpackage

/* hdl/swllm_ram.sv */
// ----------------------------------------------------------------------------
// swllm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module swllm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/swllm_div.sv */
// ----------------------------------------------------------------------------
// swllm_div
// bit serial load unit: shift-add divisor product, then restoring division
// ----------------------------------------------------------------------------
`include "sliding_window_link_load_meter_unit_macros.svh"

module swllm_div
	import swllm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  load_req_t req,
	output load_rsp_t rsp
);

	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int PROD_W = SUM_OUT_W + MICRO_W;

	div_state_t st_q, st_nxt;

	logic [DEN_W-1:0]  rem_q;
	logic [LOAD_W-1:0] quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  mcand_q;
	logic [WIN_W-1:0]  mplier_q;
	logic [STEP_W-1:0] step_q;
	logic [LOAD_W-1:0] load_q;
	logic              done_q;

	logic [PROD_W-1:0] prod;
	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic              last_step;

	// control
	logic ld_init;
	logic do_mul;
	logic do_div;
	logic sat;
	logic fin_div;

	// numerator = sum * 1e6 * 2^16; its upper word seeds the remainder
	assign prod      = req.sum * MICROS_PER_S;
	assign shifted   = {rem_q, quo_q[LOAD_W-1]};
	assign trial     = shifted - {1'b0, den_q};
	assign ge        = !trial[DEN_W];
	assign last_step = (step_q == '0);

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			DV_IDLE:  if (req.start) st_nxt = DV_MUL;
			DV_MUL:   if (last_step) st_nxt = DV_CHECK;
			DV_CHECK: st_nxt = (rem_q >= den_q) ? DV_IDLE : DV_DIV;
			DV_DIV:   if (last_step) st_nxt = DV_IDLE;
			default:  st_nxt = DV_IDLE;
		endcase
	end

	always_comb begin
		ld_init = 1'b0;
		do_mul  = 1'b0;
		do_div  = 1'b0;
		sat     = 1'b0;
		fin_div = 1'b0;
		case (st_q)
			DV_IDLE:  ld_init = req.start;
			DV_MUL:   do_mul = 1'b1;
			DV_CHECK: sat = (rem_q >= den_q);
			DV_DIV: begin
				do_div  = 1'b1;
				fin_div = last_step;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_nxt;
			done_q <= sat | fin_div;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_init) begin
			rem_q    <= DEN_W'(prod[PROD_W-1:FRAC_W]);
			quo_q    <= {prod[FRAC_W-1:0], FRAC_W'(0)};
			mcand_q  <= DEN_W'(req.bandwidth);
			mplier_q <= req.elapsed;
			den_q    <= '0;
			step_q   <= STEP_W'(MUL_STEPS - 1);
		end else if (do_mul) begin
			if (mplier_q[0]) begin
				den_q <= den_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			step_q   <= last_step ? STEP_W'(DIV_STEPS - 1) : step_q - 1'b1;
		end else if (do_div) begin
			rem_q  <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q  <= {quo_q[LOAD_W-2:0], ge};
			step_q <= step_q - 1'b1;
		end
		if (sat) begin
			load_q <= LOAD_MAX;
		end else if (fin_div) begin
			load_q <= {quo_q[LOAD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.load = load_q;

	`SWLLM_ASSERT(a_start_when_idle, clk, arst_n, req.start |-> (st_q == DV_IDLE), "load unit started while busy")
	`SWLLM_ASSERT(a_rem_below_den, clk, arst_n, (st_q == DV_DIV) |-> (rem_q < den_q), "partial remainder not below divisor")
	`SWLLM_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "load unit done held for more than one cycle")

endmodule

/* hdl/sliding_window_link_load_meter_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_link_load_meter_unit
// Measures the transmit load of one link over a sliding time window. Every
// input transaction carries a time stamp and is either a frame record
// (tuser low, frame bit count in tdata) or a query (tuser high). History
// entries older than window_us are popped from a (time, bits) fifo held in a
// ram and taken off a running bit sum; a record is then pushed unless the
// fifo is full, which flags overflow. Each item yields one output
// transaction with the saturated window bit sum and the load as unsigned
// Q16.16 of link_bandwidth, bits*1e6/(min(window_us, now_us)*bandwidth),
// flagging no_time when that elapsed time is zero. Items are handled one at
// a time: the load unit forms the divisor with a 24 step shift-add product
// and then runs a 32 step restoring division; when the load saturates the
// division is skipped, and when the elapsed time or the bandwidth is zero
// the load unit is not started and full load is given. Each expired entry
// passes through a read and a check state for the registered ram read of
// the fifo head. The output register lets the next transaction be taken
// while a result still waits. The fifo ram needs no clearing pass, only
// counted entries are ever read.
// ----------------------------------------------------------------------------
`include "sliding_window_link_load_meter_unit_macros.svh"

module sliding_window_link_load_meter_unit
	import swllm_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // now_us[47:0], frame_bits[67:48], zero pad
	input  logic                  s_tuser,   // kind
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // window_bits[27:0], load_q16[59:28], zero pad
	output logic [OUT_USER_W-1:0] m_tuser    // no_time[0], overflow[1]
);

	localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int PTR_W   = CNT_W + 1;
	localparam int SUM_W   = BITS_W + CNT_W;
	localparam int ENTRY_W = TIME_WIDTH + BITS_W;

	meter_state_t state_q, state_nxt;

	// configuration registers
	logic [WIN_W-1:0] window_q;
	logic [BW_W-1:0]  bw_q;

	// item being worked on
	logic                  kind_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [BITS_W-1:0]     fbits_q;

	// fifo bookkeeping
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;

	// result staging
	logic                 ovf_q;
	logic                 no_time_q;
	logic [SUM_OUT_W-1:0] sum_sat_q;
	logic [LOAD_W-1:0]    load_q;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	// datapath
	logic [63:0]           now_ext;
	logic [63:0]           sum_ext;
	logic [ENTRY_W-1:0]    rd_entry;
	logic [TIME_WIDTH-1:0] rd_time;
	logic [BITS_W-1:0]     rd_bits;
	logic [TIME_WIDTH-1:0] age;
	logic                  expired;
	logic                  full;
	logic [PTR_W-1:0]      tail_sum;
	logic [PTR_W-1:0]      tail_wrap;
	logic [SUM_OUT_W-1:0]  sum_sat;
	logic [WIN_W-1:0]      elapsed;
	logic                  zero_time;
	logic                  special;
	logic                  is_record;

	// control
	logic      take;
	logic      rd_en;
	logic      pop;
	logic      push;
	logic      refuse;
	logic      calc;
	logic      start;
	logic      capture;
	logic      emit;
	load_req_t req;
	load_rsp_t rsp;

	// time is kept modulo 2^TIME_WIDTH
	assign now_ext  = 64'(s_tdata[NOW_W-1:0]);
	assign rd_time  = rd_entry[BITS_W +: TIME_WIDTH];
	assign rd_bits  = rd_entry[BITS_W-1:0];
	assign age      = now_q - rd_time;
	// an entry ages out once it is strictly older than the window
	assign expired  = (age > TIME_WIDTH'(window_q));
	assign full     = (cnt_q == CNT_W'(HISTORY_DEPTH));
	assign is_record = (kind_q == KIND_RECORD);

	// tail = head + count, wrapped without a modulo
	assign tail_sum  = PTR_W'(head_q) + PTR_W'(cnt_q);
	assign tail_wrap = (tail_sum >= PTR_W'(HISTORY_DEPTH)) ?
		tail_sum - PTR_W'(HISTORY_DEPTH) : tail_sum;

	// reported sum saturates, the running sum does not
	assign sum_ext   = 64'(sum_q);
	assign sum_sat   = (sum_ext > 64'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_OUT_W-1:0];
	assign elapsed   = (now_q < TIME_WIDTH'(window_q)) ? now_q[WIN_W-1:0] : window_q;
	assign zero_time = (elapsed == '0);
	// zero elapsed time or zero bandwidth skip the divide and give full load
	assign special   = zero_time || (bw_q == '0);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_nxt = ST_READ;
			ST_READ:  state_nxt = (cnt_q != '0) ? ST_CHECK : ST_PUSH;
			ST_CHECK: state_nxt = expired ? ST_READ : ST_PUSH;
			ST_PUSH:  state_nxt = ST_CALC;
			ST_CALC:  state_nxt = special ? ST_OUT : ST_WAIT;
			ST_WAIT:  if (rsp.done) state_nxt = ST_OUT;
			ST_OUT:   if (!m_tvalid_q || m_tready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		take    = 1'b0;
		rd_en   = 1'b0;
		pop     = 1'b0;
		push    = 1'b0;
		refuse  = 1'b0;
		calc    = 1'b0;
		start   = 1'b0;
		capture = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE:  take = 1'b1;
			ST_READ:  rd_en = (cnt_q != '0);
			ST_CHECK: pop = expired;
			ST_PUSH: begin
				// queries never push and never flag overflow
				push   = is_record && !full;
				refuse = is_record && full;
			end
			ST_CALC: begin
				calc  = 1'b1;
				start = !special;
			end
			ST_WAIT:  capture = rsp.done;
			ST_OUT:   emit = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= WINDOW_RESET;
			bw_q       <= BANDWIDTH_RESET;
			head_q     <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				case (cfg_index)
					REG_WINDOW_US: window_q <= cfg_data[WIN_W-1:0];
					REG_LINK_BW:   bw_q <= cfg_data[BW_W-1:0];
					default: ;
				endcase
			end
			if (pop) begin
				head_q <= (head_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
				cnt_q  <= cnt_q - 1'b1;
				sum_q  <= sum_q - SUM_W'(rd_bits);
			end else if (push) begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_q + SUM_W'(fbits_q);
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q  <= s_tuser;
			now_q   <= now_ext[TIME_WIDTH-1:0];
			fbits_q <= s_tdata[NOW_W +: BITS_W];
			ovf_q   <= 1'b0;
		end
		if (refuse) begin
			ovf_q <= 1'b1;
		end
		if (calc) begin
			sum_sat_q <= sum_sat;
			no_time_q <= zero_time;
			load_q    <= LOAD_MAX;
		end
		if (capture) begin
			load_q <= rsp.load;
		end
		if (emit) begin
			out_data_q <= OUT_DATA_W'({load_q, sum_sat_q});
			out_user_q <= {ovf_q, no_time_q};
		end
	end

	// history fifo storage: {time, bits}
	swllm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (push),
		.waddr (tail_wrap[ADDR_W-1:0]),
		.wdata ({now_q, fbits_q}),
		.re    (rd_en),
		.raddr (head_q),
		.rdata (rd_entry)
	);

	// serial load unit
	assign req.start     = start;
	assign req.sum       = sum_sat;
	assign req.elapsed   = elapsed;
	assign req.bandwidth = bw_q;

	swllm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;

	`SWLLM_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CNT_W'(HISTORY_DEPTH), "fifo count above depth")
	`SWLLM_ASSERT(a_empty_sum, clk, arst_n, (cnt_q == '0) |-> (sum_q == '0), "bit sum not zero with empty fifo")
	`SWLLM_ASSERT_NEXT(a_push_count, clk, arst_n, push, cnt_q == $past(cnt_q) + CNT_W'(1), "push did not grow the fifo")

endmodule
